// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int FIDX_W      = $clog2(MAX_FRAMES);
  localparam int FCOUNT_W    = 4;
  localparam int TOTAL_W     = 32;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(4);
  localparam logic [FCOUNT_W-1:0] FCOUNT_MAX   = FCOUNT_W'(MAX_FRAMES);
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture the incoming reference
    logic update;     // evaluate the held reference and post its result
  } fpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rsp_free;   // result register empty or being taken this cycle
  } fpr_status_t;

endpackage

// ===== rtl/fpr_req_if.sv =====
interface fpr_req_if;
  import fpr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 last;

  modport source (output valid, page, last, input ready);
  modport sink   (input valid, page, last, output ready);
endinterface

// ===== rtl/fpr_rsp_if.sv =====
interface fpr_rsp_if;
  import fpr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 fault;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [TOTAL_W-1:0]   fault_total;
  logic                 end_of_run;

  modport source (output valid, fault, evicted_valid, evicted_page, fault_total, end_of_run,
                  input ready);
  modport sink   (input valid, fault, evicted_valid, evicted_page, fault_total, end_of_run,
                  output ready);
endinterface

// ===== rtl/fifo_page_replacement.sv =====
// FIFO page-replacement frame store. Each request transaction carries one page
// reference. It is first captured; the evaluation state then compares it against
// all frames in parallel, updates the frame store and loads the result register.
// The evaluation cycle waits while the result register still holds an untaken
// result, so the single result register sets the throughput under backpressure.
// A new reference is accepted while a finished result waits downstream.
// frame_count (1..8, reset 4) must be written only while the block is idle.
// No clearing pass follows reset; the block is ready in the first cycle.
module fifo_page_replacement (
  input  logic                         clk,
  input  logic                         rst,
  fpr_req_if.sink                      req,
  fpr_rsp_if.source                    rsp,
  input  logic                         cfg_we,
  input  logic [fpr_pkg::FCOUNT_W-1:0] cfg_wdata
);
  import fpr_pkg::*;

  fpr_cmd_t    cmd;
  fpr_status_t status;

  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fpr_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .req_page          (req.page),
    .req_last          (req.last),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_fault         (rsp.fault),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_page  (rsp.evicted_page),
    .rsp_fault_total   (rsp.fault_total),
    .rsp_end_of_run    (rsp.end_of_run)
  );

endmodule

// ===== rtl/fpr_ctrl.sv =====
module fpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fpr_pkg::fpr_status_t status,
  output fpr_pkg::fpr_cmd_t   cmd
);
  import fpr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd.load_req = 1'b0;
    cmd.update   = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        // hold the reference until the result register can take it
        if (status.rsp_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fpr_dp.sv =====
module fpr_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  fpr_pkg::fpr_cmd_t               cmd,
  output fpr_pkg::fpr_status_t            status,
  input  logic                            cfg_we,
  input  logic [fpr_pkg::FCOUNT_W-1:0]    cfg_wdata,
  input  logic [fpr_pkg::PAGE_BITS-1:0]   req_page,
  input  logic                            req_last,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            rsp_fault,
  output logic                            rsp_evicted_valid,
  output logic [fpr_pkg::PAGE_BITS-1:0]   rsp_evicted_page,
  output logic [fpr_pkg::TOTAL_W-1:0]     rsp_fault_total,
  output logic                            rsp_end_of_run
);
  import fpr_pkg::*;

  logic [FCOUNT_W-1:0]  frame_count;
  logic [PAGE_BITS-1:0] held_page;
  logic                 held_last;

  logic [PAGE_BITS-1:0] frame_page  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [FCOUNT_W-1:0]  filled_frames;
  logic [FIDX_W-1:0]    oldest_frame;
  logic [TOTAL_W-1:0]   fault_counter;

  logic [FCOUNT_W-1:0]  cap;
  logic                 hit;
  logic                 has_free;
  logic [FIDX_W-1:0]    slot;
  logic [FCOUNT_W-1:0]  slot_inc;
  logic [FIDX_W-1:0]    oldest_next;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic [TOTAL_W-1:0]   fault_counter_next;

  assign status.rsp_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FCOUNT_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      held_page <= req_page;
      held_last <= req_last;
    end
  end

  // frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      cap = FCOUNT_W'(1);
    end else if (frame_count > FCOUNT_MAX) begin
      cap = FCOUNT_MAX;
    end else begin
      cap = frame_count;
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if ((FCOUNT_W'(i) < cap) && frame_valid[i] && (frame_page[i] == held_page)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    has_free = filled_frames < cap;
    if (has_free) begin
      slot = filled_frames[FIDX_W-1:0];
    end else if ({1'b0, oldest_frame} >= cap) begin
      slot = '0;
    end else begin
      slot = oldest_frame;
    end
    slot_inc    = FCOUNT_W'(slot) + FCOUNT_W'(1);
    oldest_next = (slot_inc >= cap) ? '0 : slot_inc[FIDX_W-1:0];
    ev_valid    = !hit && !has_free && frame_valid[slot];
    ev_page     = ev_valid ? frame_page[slot] : '0;
    if (!hit && (fault_counter != TOTAL_MAX)) begin
      fault_counter_next = fault_counter + TOTAL_W'(1);
    end else begin
      fault_counter_next = fault_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !hit) begin
      frame_page[slot] <= held_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      filled_frames <= '0;
      oldest_frame  <= '0;
      fault_counter <= '0;
    end else if (cmd.update) begin
      if (held_last) begin
        frame_valid   <= '0;
        filled_frames <= '0;
        oldest_frame  <= '0;
        fault_counter <= '0;
      end else begin
        fault_counter <= fault_counter_next;
        if (!hit) begin
          frame_valid[slot] <= 1'b1;
          if (has_free) begin
            filled_frames <= filled_frames + FCOUNT_W'(1);
          end else begin
            oldest_frame <= oldest_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.update) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp_fault         <= !hit;
      rsp_evicted_valid <= ev_valid;
      rsp_evicted_page  <= ev_page;
      rsp_fault_total   <= fault_counter_next;
      rsp_end_of_run    <= held_last;
    end
  end

endmodule

// ===== rtl/fpr_checker.sv =====
module fpr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_fault,
  input logic                         rsp_evicted_valid,
  input logic [fpr_pkg::PAGE_BITS-1:0] rsp_evicted_page,
  input logic [fpr_pkg::TOTAL_W-1:0]   rsp_fault_total
);
  import fpr_pkg::*;

  // one reference in evaluation at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted on consecutive cycles");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_evicted_valid) |-> rsp_fault)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  a_total_counts_fault: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_fault) |-> (rsp_fault_total != '0))
    else $error("fault reported with zero fault total");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fault_total)))
    else $error("stalled result changed");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_fault         (rsp.fault),
  .rsp_evicted_valid (rsp.evicted_valid),
  .rsp_evicted_page  (rsp.evicted_page),
  .rsp_fault_total   (rsp.fault_total)
);
